FILE: hdl/bscfn_pkg.sv
// ----------------------------------------------------------------------------
// bscfn_pkg
// Shared types, request codes and helpers for the flag bitmap core.
// ----------------------------------------------------------------------------
package bscfn_pkg;

	// Flag bits held in one stored word
	localparam int unsigned WordBits = 64;
	localparam int unsigned OffBits  = 6;
	// Words reachable through an 8-bit bit index
	localparam int unsigned IdxWords = 4;

	// Request codes
	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_TEST   = 2'd1,
		KIND_FIND   = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	// Sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EVAL = 1'b1
	} state_t;

	// Position of the lowest set bit of a nonzero word (binary narrowing)
	function automatic logic [OffBits-1:0] lowest_set(input logic [WordBits-1:0] v);
		logic [WordBits-1:0] t;
		logic [OffBits-1:0]  pos;
		t   = v;
		pos = '0;
		if (t[31:0] == 32'd0) begin
			t      = t >> 32;
			pos[5] = 1'b1;
		end
		if (t[15:0] == 16'd0) begin
			t      = t >> 16;
			pos[4] = 1'b1;
		end
		if (t[7:0] == 8'd0) begin
			t      = t >> 8;
			pos[3] = 1'b1;
		end
		if (t[3:0] == 4'd0) begin
			t      = t >> 4;
			pos[2] = 1'b1;
		end
		if (t[1:0] == 2'd0) begin
			t      = t >> 2;
			pos[1] = 1'b1;
		end
		if (t[0] == 1'b0) begin
			pos[0] = 1'b1;
		end
		return pos;
	endfunction

endpackage

FILE: hdl/bscfn_ram.sv
// ----------------------------------------------------------------------------
// bscfn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bscfn_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 4
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/bitmap_set_clear_find_next_core.sv
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_next_core
// Flag bitmap with bit write, bit test and find-next-set over 64-bit words.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result is
// shown for one cycle with done high and must be captured then. The words live
// in a RAM with one registered read port, and the sequencer reads one word per
// cycle: a write or a test evaluates its one word, while a find scans words
// upward from the requested one, at most min(NUM_WORDS, 4) of them, as an
// 8-bit index reaches only four words. The result appears the cycle after the
// last word is evaluated, and a new request may be taken in that same cycle.
// Words are cleared at reset through per-word valid bits, so no clearing pass
// is needed. map_valid is high when the owner id is nonzero and some word
// holds a set bit after the request.
// ----------------------------------------------------------------------------
module bitmap_set_clear_find_next_core #(
	parameter int unsigned NUM_WORDS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  bit_index,
	input  logic        set_value,
	// result side
	output logic        done,
	output logic        bit_is_set,
	output logic        found,
	output logic [7:0]  next_index,
	output logic        map_valid,
	// owner id register
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int unsigned AddrBits = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int unsigned MapWords =
		(NUM_WORDS < bscfn_pkg::IdxWords) ? NUM_WORDS : bscfn_pkg::IdxWords;
	localparam logic [1:0]  LastWord = 2'(MapWords - 1);

	// Sequencer and request registers
	bscfn_pkg::state_t                  state_q, state_d;
	bscfn_pkg::kind_t                   kind_q;
	logic [1:0]                         word_q;
	logic [bscfn_pkg::OffBits-1:0]      off_q;
	logic                               set_q;
	logic                               in_map_q;
	logic                               rd_valid_q;
	logic [NUM_WORDS-1:0]               valid_q;
	logic [NUM_WORDS-1:0]               nz_q;
	logic [31:0]                        owner_q;

	// Result registers
	logic                               done_q;
	logic                               bit_is_set_q;
	logic                               found_q;
	logic [7:0]                         next_index_q;
	logic                               map_valid_q;

	// RAM port signals
	logic                               ram_we;
	logic [AddrBits-1:0]                ram_waddr;
	logic [bscfn_pkg::WordBits-1:0]     ram_wdata;
	logic [AddrBits-1:0]                ram_raddr;
	logic [bscfn_pkg::WordBits-1:0]     ram_rdata;
	logic [1:0]                         rword;
	logic [7:0]                         rword_ext;
	logic [7:0]                         wword_ext;

	// Datapath
	logic [bscfn_pkg::WordBits-1:0]     cur_word;
	logic [bscfn_pkg::WordBits-1:0]     bit_mask;
	logic [bscfn_pkg::WordBits-1:0]     hit;
	logic [bscfn_pkg::WordBits-1:0]     new_word;
	logic [NUM_WORDS-1:0]               nz_d;
	logic                               go_next;
	logic                               finish;
	logic                               res_set;
	logic                               res_found;
	logic [7:0]                         res_index;
	logic                               accept;

	assign accept = start && (state_q == bscfn_pkg::ST_IDLE);

	bscfn_ram #(
		.WIDTH (bscfn_pkg::WordBits),
		.DEPTH (NUM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Read address: requested word when idle, following word while scanning
	assign rword     = (state_q == bscfn_pkg::ST_IDLE) ? bit_index[7:6] : word_q + 2'd1;
	assign rword_ext = {6'd0, rword};
	assign ram_raddr = rword_ext[AddrBits-1:0];
	assign wword_ext = {6'd0, word_q};
	assign ram_waddr = wword_ext[AddrBits-1:0];

	// Word as seen by the request: never-written words read as zero
	assign cur_word = rd_valid_q ? ram_rdata : '0;
	assign bit_mask = {{(bscfn_pkg::WordBits-1){1'b0}}, 1'b1} << off_q;
	assign hit      = cur_word & ({bscfn_pkg::WordBits{1'b1}} << off_q);
	assign new_word = set_q ? (cur_word | bit_mask) : (cur_word & ~bit_mask);
	assign ram_wdata = new_word;

	// Next state, RAM write and result values
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		nz_d      = nz_q;
		go_next   = 1'b0;
		finish    = 1'b0;
		res_set   = 1'b0;
		res_found = 1'b0;
		res_index = '0;
		unique case (state_q)
			bscfn_pkg::ST_IDLE: begin
				if (start) begin
					state_d = bscfn_pkg::ST_EVAL;
				end
			end
			bscfn_pkg::ST_EVAL: begin
				finish = 1'b1;
				unique case (kind_q)
					bscfn_pkg::KIND_WRITE: begin
						if (in_map_q) begin
							ram_we = 1'b1;
							nz_d[ram_waddr] = |new_word;
						end
					end
					bscfn_pkg::KIND_TEST: begin
						res_set = in_map_q && ((cur_word & bit_mask) != '0);
					end
					bscfn_pkg::KIND_FIND: begin
						if (in_map_q) begin
							if (hit != '0) begin
								res_found = 1'b1;
								res_index = {word_q, bscfn_pkg::lowest_set(hit)};
							end else if (word_q != LastWord) begin
								go_next = 1'b1;
								finish  = 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
				if (finish) begin
					state_d = bscfn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bscfn_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bscfn_pkg::ST_IDLE;
			valid_q    <= '0;
			nz_q       <= '0;
			owner_q    <= '0;
			done_q     <= 1'b0;
			rd_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			nz_q       <= nz_d;
			done_q     <= finish;
			rd_valid_q <= valid_q[ram_raddr];
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (cfg_we) begin
				owner_q <= cfg_wdata;
			end
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= bscfn_pkg::kind_t'(kind);
			word_q   <= bit_index[7:6];
			off_q    <= bit_index[5:0];
			set_q    <= set_value;
			in_map_q <= (int'(bit_index[7:6]) < int'(NUM_WORDS));
		end else if (go_next) begin
			word_q <= word_q + 2'd1;
			off_q  <= '0;
		end
		if (finish) begin
			bit_is_set_q <= res_set;
			found_q      <= res_found;
			next_index_q <= res_index;
			map_valid_q  <= (owner_q != 32'd0) && (nz_d != '0);
		end
	end

	assign busy       = (state_q != bscfn_pkg::ST_IDLE);
	assign done       = done_q;
	assign bit_is_set = bit_is_set_q;
	assign found      = found_q;
	assign next_index = next_index_q;
	assign map_valid  = map_valid_q;

endmodule
